// ===== rtl/core/pglm_pkg.sv =====
package pglm_pkg;

    // Handshake state of the shared divider as seen by its sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } pglm_div_status_t;

endpackage

// ===== rtl/core/pglm_div.sv =====
module pglm_div #(
    parameter int PERIOD_BITS = 31
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [PERIOD_BITS-1:0]       dividend,
    input  logic [PERIOD_BITS-1:0]       divisor,
    output logic [PERIOD_BITS-1:0]       quotient,
    output logic [PERIOD_BITS-1:0]       remainder,
    output pglm_pkg::pglm_div_status_t   status
);
    import pglm_pkg::*;

    localparam int CNT_W = $clog2(PERIOD_BITS);

    logic [PERIOD_BITS-1:0] rem_reg;
    logic [PERIOD_BITS-1:0] quo_reg;
    logic [PERIOD_BITS-1:0] div_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [PERIOD_BITS:0]   shifted;
    logic [PERIOD_BITS:0]   diff;
    logic                   fits;
    logic [PERIOD_BITS-1:0] rem_next;
    logic [PERIOD_BITS-1:0] quo_next;

    // One restoring step per cycle, most significant quotient bit first.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[PERIOD_BITS-1]};
        diff     = shifted - {1'b0, div_reg};
        fits     = (shifted >= {1'b0, div_reg});
        rem_next = fits ? diff[PERIOD_BITS-1:0] : shifted[PERIOD_BITS-1:0];
        quo_next = {quo_reg[PERIOD_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PERIOD_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/core/period_gcd_lcm_min.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata: period; tlast: last period of the set
// m_axis    out        tdata: minor_cycle, hyperperiod, shortest_period; tuser: overflow
//
// The first period of a set only seeds the running values and goes straight to
// the closing state. Any later period runs two Euclid loops on one shared
// divider, then one division, a shift-add multiply and the closing state; the
// LCM work is skipped once the set has saturated. s_axis_tready is high only
// while the sequencer is idle. A finished result waits in the output register;
// a further result stalls until it is taken.
module period_gcd_lcm_min #(
    parameter int PERIOD_BITS = 31
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // period
    input  logic [((PERIOD_BITS + 7) / 8) * 8 - 1:0]   s_axis_tdata,
    input  logic                                       s_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // minor_cycle, hyperperiod, shortest_period
    output logic [((3 * PERIOD_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // overflow
    output logic                                       m_axis_tuser
);
    import pglm_pkg::*;

    localparam int PB    = PERIOD_BITS;
    localparam int OUT_W = ((3 * PERIOD_BITS + 7) / 8) * 8;
    localparam int CNT_W = $clog2(PERIOD_BITS);
    localparam logic [PB-1:0] MAX_VAL = {PB{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EUC_TEST,
        ST_EUC_DIV,
        ST_QUOT,
        ST_MUL,
        ST_FIN
    } state_t;

    typedef enum logic {
        PH_GCD,
        PH_LCM
    } phase_t;

    state_t           state_reg;
    phase_t           phase_reg;
    logic             set_open_reg;
    logic             ovf_reg;
    logic             last_reg;
    logic [PB-1:0]    gcd_reg;
    logic [PB-1:0]    lcm_reg;
    logic [PB-1:0]    min_reg;
    logic [PB-1:0]    p_reg;
    logic [PB-1:0]    ea_reg;
    logic [PB-1:0]    eb_reg;
    logic [PB-1:0]    q_reg;
    logic [PB+1:0]    acc_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic             out_valid_reg;
    logic [PB-1:0]    out_gcd_reg;
    logic [PB-1:0]    out_lcm_reg;
    logic [PB-1:0]    out_min_reg;
    logic             out_ovf_reg;

    logic [PB-1:0]    p_in;
    logic [PB-1:0]    cur_lcm;
    logic [PB+1:0]    acc_next;
    logic             acc_over;
    logic             div_start;
    logic [PB-1:0]    div_dividend;
    logic [PB-1:0]    div_divisor;
    logic [PB-1:0]    div_quot;
    logic [PB-1:0]    div_rem;
    pglm_div_status_t div_status;
    logic             out_free;
    logic             out_load;

    always_comb
    begin
        p_in     = (s_axis_tdata[PB-1:0] == '0) ? PB'(1) : s_axis_tdata[PB-1:0];
        cur_lcm  = (lcm_reg == '0) ? PB'(1) : lcm_reg;
        acc_next = {acc_reg[PB:0], 1'b0} + (q_reg[PB-1] ? {2'b00, p_reg} : '0);
        acc_over = (acc_next > {2'b00, MAX_VAL});
        out_free = !out_valid_reg || m_axis_tready;
        out_load = (state_reg == ST_FIN) && last_reg && out_free;

        div_start    = 1'b0;
        div_dividend = eb_reg;
        div_divisor  = ea_reg;
        if (state_reg == ST_EUC_TEST)
        begin
            if (ea_reg != '0)
            begin
                div_start = 1'b1;
            end
            else if (phase_reg == PH_LCM)
            begin
                div_start    = 1'b1;
                div_dividend = cur_lcm;
                div_divisor  = eb_reg;
            end
        end
    end

    pglm_div #(
        .PERIOD_BITS(PERIOD_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .remainder(div_rem),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_GCD;
            set_open_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            gcd_reg       <= '0;
            lcm_reg       <= '0;
            min_reg       <= '0;
            p_reg         <= '0;
            ea_reg        <= '0;
            eb_reg        <= '0;
            q_reg         <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_gcd_reg   <= '0;
            out_lcm_reg   <= '0;
            out_min_reg   <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        p_reg    <= p_in;
                        last_reg <= s_axis_tlast;
                        if (!set_open_reg)
                        begin
                            gcd_reg      <= p_in;
                            lcm_reg      <= p_in;
                            min_reg      <= p_in;
                            ovf_reg      <= 1'b0;
                            set_open_reg <= 1'b1;
                            state_reg    <= ST_FIN;
                        end
                        else
                        begin
                            if (p_in < min_reg)
                            begin
                                min_reg <= p_in;
                            end
                            ea_reg    <= p_in;
                            eb_reg    <= gcd_reg;
                            phase_reg <= PH_GCD;
                            state_reg <= ST_EUC_TEST;
                        end
                    end
                end

                ST_EUC_TEST:
                begin
                    if (ea_reg != '0)
                    begin
                        state_reg <= ST_EUC_DIV;
                    end
                    else if (phase_reg == PH_GCD)
                    begin
                        gcd_reg <= eb_reg;
                        if (ovf_reg)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            ea_reg    <= p_reg;
                            eb_reg    <= cur_lcm;
                            phase_reg <= PH_LCM;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_QUOT;
                    end
                end

                ST_EUC_DIV:
                begin
                    if (div_status.done)
                    begin
                        eb_reg    <= ea_reg;
                        ea_reg    <= div_rem;
                        state_reg <= ST_EUC_TEST;
                    end
                end

                ST_QUOT:
                begin
                    if (div_status.done)
                    begin
                        q_reg     <= div_quot;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    acc_reg <= acc_next;
                    q_reg   <= {q_reg[PB-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (acc_over)
                    begin
                        lcm_reg   <= MAX_VAL;
                        ovf_reg   <= 1'b1;
                        state_reg <= ST_FIN;
                    end
                    else if (cnt_reg == CNT_W'(PB - 1))
                    begin
                        lcm_reg   <= acc_next[PB-1:0];
                        state_reg <= ST_FIN;
                    end
                end

                ST_FIN:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_gcd_reg   <= gcd_reg;
                        out_lcm_reg   <= lcm_reg;
                        out_min_reg   <= min_reg;
                        out_ovf_reg   <= ovf_reg;
                        gcd_reg       <= '0;
                        lcm_reg       <= '0;
                        min_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        set_open_reg  <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_min_reg, out_lcm_reg, out_gcd_reg});
    assign m_axis_tuser  = out_ovf_reg;

endmodule

// ===== tb/period_gcd_lcm_min_test.sv =====
`timescale 1ns / 1ps

module period_gcd_lcm_min_test;

    localparam int PB = 31;
    localparam logic [63:0] PERIOD_MAX = (64'd1 << PB) - 1;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int DRAIN_CYCLES = 4 * (PB + 2) * 48;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct packed {
        logic [PB-1:0] minor_cycle;
        logic [PB-1:0] hyperperiod;
        logic [PB-1:0] shortest_period;
        logic          overflow;
    } schedule_t;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        typed;
        schedule_t   sched;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;

    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           error_count = 0;
    int           cycle_count = 0;

    logic [63:0]  acc_gcd = '0;
    logic [63:0]  acc_lcm = '0;
    logic [63:0]  acc_min = '0;
    logic         acc_sat = 1'b0;
    logic         acc_open = 1'b0;

    schedule_t    pending_schedules[$];
    stim_row_t    directed_rows[$];

    period_gcd_lcm_min #(
        .PERIOD_BITS(PB)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    function automatic logic [63:0] euclid_gcd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        while (a != 0)
        begin
            r = b % a;
            b = a;
            a = r;
        end
        return b;
    endfunction

    function automatic stim_row_t stim_row(input logic [31:0] word, input logic last,
                                           input logic typed, input logic [63:0] mc,
                                           input logic [63:0] hp, input logic [63:0] sp,
                                           input logic ov);
        stim_row_t row;
        row.word = word;
        row.last = last;
        row.typed = typed;
        row.sched.minor_cycle = mc[PB-1:0];
        row.sched.hyperperiod = hp[PB-1:0];
        row.sched.shortest_period = sp[PB-1:0];
        row.sched.overflow = ov;
        return row;
    endfunction

    // Folds one period into the running set and closes the set on its last period.
    task automatic absorb_period(input logic [31:0] word, input logic last,
                                 output logic emits, output schedule_t sched);
        logic [63:0] p;
        logic [63:0] cur;
        logic [63:0] g;
        logic [63:0] q;
        p = {33'd0, word[PB-1:0]};
        if (p == 0)
            p = 1;
        if (!acc_open)
        begin
            acc_gcd = p;
            acc_lcm = p;
            acc_min = p;
            acc_sat = 1'b0;
            acc_open = 1'b1;
        end
        else
        begin
            acc_gcd = euclid_gcd(p, acc_gcd);
            if (p < acc_min)
                acc_min = p;
            if (!acc_sat)
            begin
                cur = (acc_lcm == 0) ? 64'd1 : acc_lcm;
                g = euclid_gcd(p, cur);
                q = cur / g;
                if (q > PERIOD_MAX / p)
                begin
                    acc_lcm = PERIOD_MAX;
                    acc_sat = 1'b1;
                end
                else
                    acc_lcm = q * p;
            end
        end
        emits = last;
        sched.minor_cycle = acc_gcd[PB-1:0];
        sched.hyperperiod = acc_lcm[PB-1:0];
        sched.shortest_period = acc_min[PB-1:0];
        sched.overflow = acc_sat;
        if (last)
        begin
            acc_gcd = '0;
            acc_lcm = '0;
            acc_min = '0;
            acc_sat = 1'b0;
            acc_open = 1'b0;
        end
    endtask

    task automatic send_request(input logic [31:0] word, input logic last,
                                input logic typed, input schedule_t typed_sched);
        logic      emits;
        schedule_t sched;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        absorb_period(word, last, emits, sched);
        if (emits)
            pending_schedules.push_back(typed ? typed_sched : sched);
    endtask

    always @(posedge clk)
    begin
        schedule_t got;
        schedule_t want;
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.minor_cycle = m_axis_tdata[PB-1:0];
            got.hyperperiod = m_axis_tdata[2*PB-1:PB];
            got.shortest_period = m_axis_tdata[3*PB-1:2*PB];
            got.overflow = m_axis_tuser;
            if (pending_schedules.size() == 0)
                report_mismatch("result with no request pending", 64'(got.minor_cycle),
                                64'd0);
            else
            begin
                want = pending_schedules.pop_front();
                if (got.minor_cycle !== want.minor_cycle)
                    report_mismatch("minor_cycle", 64'(got.minor_cycle),
                                    64'(want.minor_cycle));
                if (got.hyperperiod !== want.hyperperiod)
                    report_mismatch("hyperperiod", 64'(got.hyperperiod),
                                    64'(want.hyperperiod));
                if (got.shortest_period !== want.shortest_period)
                    report_mismatch("shortest_period", 64'(got.shortest_period),
                                    64'(want.shortest_period));
                if (got.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
            end
        end
    end

    initial
    begin
        int          phase;
        int          items;
        int          set_len;
        int          sel;
        logic [31:0] base;
        logic [31:0] word;
        schedule_t   no_sched;
        no_sched = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_rows.push_back(stim_row(32'd5, 1'b1, 1'b1, 5, 5, 5, 1'b0));
        directed_rows.push_back(stim_row(32'd0, 1'b1, 1'b1, 1, 1, 1, 1'b0));
        directed_rows.push_back(stim_row(PERIOD_MAX[31:0], 1'b1, 1'b1, PERIOD_MAX,
                                         PERIOD_MAX, PERIOD_MAX, 1'b0));
        directed_rows.push_back(stim_row(32'h8000_0005, 1'b1, 1'b1, 5, 5, 5, 1'b0));
        directed_rows.push_back(stim_row(32'd1, 1'b1, 1'b1, 1, 1, 1, 1'b0));
        directed_rows.push_back(stim_row(32'd12, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd18, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd30, 1'b1, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(PERIOD_MAX[31:0], 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(PERIOD_MAX[31:0] - 32'd1, 1'b1, 1'b1, 1,
                                         PERIOD_MAX, PERIOD_MAX - 1, 1'b1));
        directed_rows.push_back(stim_row(32'd1_000_000, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'h4000_0000, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd7, 1'b1, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd0, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd8, 1'b1, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'hFFFF_FFFF, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd3, 1'b1, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'h4000_0000, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'h4000_0000, 1'b1, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd46340, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd46341, 1'b1, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd46341, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd46342, 1'b1, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd65536, 1'b0, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(stim_row(32'd32768, 1'b1, 1'b0, 0, 0, 0, 1'b0));

        foreach (directed_rows[i])
            send_request(directed_rows[i].word, directed_rows[i].last,
                         directed_rows[i].typed, directed_rows[i].sched);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            items = 0;
            while (items < ITEMS_PER_PHASE)
            begin
                set_len = $urandom_range(1, 6);
                base = $urandom_range(1, 50000);
                for (int k = 0; k < set_len; k++)
                begin
                    sel = $urandom_range(99);
                    if (sel < 35)
                        word = $urandom_range(1, 64);
                    else if (sel < 55)
                        word = base * $urandom_range(1, 40);
                    else if (sel < 75)
                        word = $urandom;
                    else if (sel < 85)
                        word = 32'd1 << $urandom_range(0, PB - 1);
                    else if (sel < 90)
                        word = {1'($urandom_range(1)), 31'd0};
                    else
                        word = PERIOD_MAX[31:0] - $urandom_range(0, 3);
                    send_request(word, k == set_len - 1, 1'b0, no_sched);
                end
                items += set_len;
            end
            if (phase == 1)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_schedules.size() != 0)
                    @(posedge clk);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_schedules.size() != 0 || !s_axis_tready)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
